>>> design/sed_pkg.sv
// Shared types, constants and helpers for the string escape decoder.
package sed_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_A      = 8'h61;

	localparam logic [7:0] CODE_CR  = 8'd13;
	localparam logic [7:0] CODE_LF  = 8'd10;
	localparam logic [7:0] CODE_TAB = 8'd9;
	localparam logic [7:0] CODE_VT  = 8'd11;
	localparam logic [7:0] CODE_BEL = 8'd7;

	localparam logic [10:0] DEC_LIMIT = 11'd128;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_CONT   = 3'd2,
		MODE_DEC1   = 3'd3,
		MODE_DEC2   = 3'd4
	} mode_t;

	// One decoded result as it leaves the block, less the run_last flag.
	typedef struct packed {
		logic [7:0] ch;
		logic       char_valid;
		logic       string_end;
	} result_t;

	// Everything one input byte produces: one or two results.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] map_escape(input logic [7:0] b);
		logic [7:0] c;
		unique case (b)
			CH_R:    c = CODE_CR;
			CH_N:    c = CODE_LF;
			CH_T:    c = CODE_TAB;
			CH_V:    c = CODE_VT;
			CH_A:    c = CODE_BEL;
			default: c = b;
		endcase
		return c;
	endfunction

	function automatic result_t char_result(input logic [7:0] c);
		result_t r;
		r.ch         = c;
		r.char_valid = 1'b1;
		r.string_end = 1'b0;
		return r;
	endfunction

	function automatic result_t end_result();
		result_t r;
		r.ch         = 8'd0;
		r.char_valid = 1'b0;
		r.string_end = 1'b1;
		return r;
	endfunction

endpackage

>>> design/sed_front.sv
// Front end: accepts raw bytes, runs the escape state machine and queues results.
module sed_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  sed_pkg::q_status_t q_status,
	output logic              push,
	output sed_pkg::entry_t   push_entry
);
	import sed_pkg::*;

	mode_t      mode_q, mode_d;
	logic [6:0] value_q, value_d;

	logic        accept;
	logic        is_digit;
	logic [3:0]  digit;
	logic [10:0] prod;
	logic        nb_emit;
	mode_t       nb_mode;
	result_t     nb_res;
	logic        any_res;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign digit    = 4'(in_byte - CH_ZERO);
	assign prod     = 11'(value_q) * 11'd10 + 11'(digit);

	// What the byte does when taken as plain text.
	always_comb begin
		nb_emit = 1'b1;
		nb_mode = MODE_NORMAL;
		nb_res  = char_result(in_byte);
		if (in_byte == CH_BSLASH) begin
			nb_emit = 1'b0;
			nb_mode = MODE_ESC;
		end else if (in_byte == CH_QUOTE) begin
			nb_res = end_result();
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			value_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			value_q <= value_d;
		end
	end

	always_comb begin
		mode_d          = mode_q;
		value_d         = value_q;
		any_res         = 1'b0;
		push_entry.two  = 1'b0;
		push_entry.r0   = nb_res;
		push_entry.r1   = nb_res;
		unique case (mode_q)
			MODE_ESC: begin
				if (in_byte == CH_NL) begin
					mode_d = MODE_CONT;
				end else if (is_digit) begin
					value_d = 7'(digit);
					mode_d  = MODE_DEC1;
				end else begin
					mode_d        = MODE_NORMAL;
					any_res       = 1'b1;
					push_entry.r0 = char_result(map_escape(in_byte));
				end
			end
			MODE_CONT: begin
				if (in_byte == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					mode_d        = MODE_NORMAL;
					any_res       = 1'b1;
					push_entry.r0 = char_result(in_byte);
				end
			end
			MODE_DEC1: begin
				if (is_digit) begin
					value_d = prod[6:0];
					mode_d  = MODE_DEC2;
				end else begin
					value_d        = '0;
					mode_d         = nb_mode;
					any_res        = 1'b1;
					push_entry.r0  = char_result({1'b0, value_q});
					push_entry.two = nb_emit;
				end
			end
			MODE_DEC2: begin
				value_d = '0;
				any_res = 1'b1;
				if (is_digit && (prod < DEC_LIMIT)) begin
					mode_d        = MODE_NORMAL;
					push_entry.r0 = char_result(prod[7:0]);
				end else begin
					mode_d         = nb_mode;
					push_entry.r0  = char_result({1'b0, value_q});
					push_entry.two = nb_emit;
				end
			end
			default: begin
				mode_d  = nb_mode;
				any_res = nb_emit;
			end
		endcase
	end

	assign push = accept && any_res;

	// The gathered value is only ever live inside a decimal escape.
	a_value_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_NORMAL || mode_q == MODE_ESC || mode_q == MODE_CONT)
			|-> (value_q == 7'd0))
		else $error("escape value not cleared outside a decimal escape");

	// After one digit the value is a single decimal digit.
	a_dec1_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DEC1) |-> (value_q <= 7'd9))
		else $error("single-digit escape value out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("queue written while full");

endmodule

>>> design/sed_queue.sv
// Short queue of decoded result pairs between the front and back ends.
module sed_queue #(
	parameter int DEPTH = sed_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sed_pkg::entry_t    push_entry,
	input  logic               pop,
	output sed_pkg::entry_t    head,
	output sed_pkg::q_status_t q_status
);
	import sed_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign q_status.full  = (count_q == CNT_W'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	// When the queue is empty the two pointers are equal.
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with an empty count");

endmodule

>>> design/sed_back.sv
// Back end: unpacks queued result pairs into single results in the output register.
module sed_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sed_pkg::entry_t    head,
	input  sed_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               char_valid,
	output logic               string_end,
	output logic               run_last
);
	import sed_pkg::*;

	logic    valid_q;
	logic    idx_q;
	result_t res_q;
	logic    last_q;
	logic    load;
	logic    take;
	logic    is_last;

	assign load    = !valid_q || out_ready;
	assign take    = load && !q_status.empty;
	assign is_last = idx_q || !head.two;
	assign pop     = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !q_status.empty;
			if (take) begin
				idx_q <= !is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q  <= idx_q ? head.r1 : head.r0;
			last_q <= is_last;
		end
	end

	assign out_valid  = valid_q;
	assign out_char   = res_q.ch;
	assign char_valid = res_q.char_valid;
	assign string_end = res_q.string_end;
	assign run_last   = last_q;

	// The second half of a pair is already queued when the first leaves.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_ready && !last_q) |=> valid_q)
		else $error("second result of a byte not delivered next");

	a_idx_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (!q_status.empty && head.two))
		else $error("second-result index without a pair at the head");

	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && string_end) |-> (!char_valid && out_char == 8'd0))
		else $error("end marker carries a character");

endmodule

>>> design/string_escape_decoder.sv
// Top level of the string escape decoder.
//
// Input channel: in_valid / in_ready carry one raw byte of a string literal body
// per transaction, starting after the opening quote. Output channel: out_valid /
// out_ready carry one decoded result per transaction: a character (char_valid),
// or an end marker (string_end) for the closing quote. run_last marks the last
// result that an input byte caused; a byte may cause none, one or two results.
// An accepted byte's results pass first through the queue, then into the output
// register of the back end. Throughput: one byte per cycle while the queue has
// room; a byte other than a backslash that closes a decimal escape early gives
// two results, which leave in turn through the single-result output register.
// A queue of QUEUE_DEPTH byte records separates the decoder state machine from
// the output register, so input keeps flowing while the receiver stalls; once
// the queue is full in_ready drops until the receiver takes results again.
// Reset puts the decoder in normal text mode and empties the queue and the
// output register. After a closing quote, the next bytes begin a new literal.
module string_escape_decoder #(
	parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       string_end,
	output logic       run_last
);
	import sed_pkg::*;

	q_status_t q_status;
	logic      push;
	logic      pop;
	entry_t    push_entry;
	entry_t    head;

	sed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	sed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	sed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.char_valid (char_valid),
		.string_end (string_end),
		.run_last   (run_last)
	);

endmodule

>>> tb/string_escape_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the string escape decoder: random handshakes and a byte-level predictor.
module string_escape_decoder_tb;
	import sed_pkg::*;

	localparam int ITEM_TARGET  = 1650;
	localparam int QUIET_TAIL   = 150;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0] ch;
		logic       char_ok;
		logic       str_end;
		logic       last;
	} decoded_t;

	typedef struct packed {
		logic [7:0] b;
		logic       drain;
	} raw_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       char_valid;
	logic       string_end;
	logic       run_last;

	raw_t       pending[$];
	decoded_t   decoded_q[$];
	decoded_t   byte_results[$];
	mode_t      mode      = MODE_NORMAL;
	logic [6:0] dec_acc   = 7'd0;
	int         errors    = 0;
	int         cycles    = 0;
	bit         in_taken  = 1'b0;
	int         send_gap  = 0;
	int         recv_gap  = 0;

	string_escape_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.char_valid (char_valid),
		.string_end (string_end),
		.run_last   (run_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void push_char(logic [7:0] c);
		decoded_t r;
		r.ch      = c;
		r.char_ok = 1'b1;
		r.str_end = 1'b0;
		r.last    = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void push_end();
		decoded_t r;
		r.ch      = 8'd0;
		r.char_ok = 1'b0;
		r.str_end = 1'b1;
		r.last    = 1'b0;
		byte_results.push_back(r);
	endfunction

	// A byte seen in plain text: a backslash opens an escape, a quote closes the string.
	function automatic void text_byte(logic [7:0] b);
		if (b == CH_BSLASH) begin
			mode = MODE_ESC;
		end else begin
			mode = MODE_NORMAL;
			if (b == CH_QUOTE)
				push_end();
			else
				push_char(b);
		end
	endfunction

	// Advances the decoder state by one raw byte and queues whatever it produces.
	function automatic void decode_byte(logic [7:0] b);
		int  v;
		int  d;
		bit  is_dig;
		byte_results.delete();
		v = int'(dec_acc);
		d = int'(b) - int'(CH_ZERO);
		is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
		case (mode)
			MODE_ESC: begin
				if (b == CH_NL) begin
					mode = MODE_CONT;
				end else if (is_dig) begin
					dec_acc = 7'(d);
					mode = MODE_DEC1;
				end else begin
					mode = MODE_NORMAL;
					case (b)
						CH_R:    push_char(CODE_CR);
						CH_N:    push_char(CODE_LF);
						CH_T:    push_char(CODE_TAB);
						CH_V:    push_char(CODE_VT);
						CH_A:    push_char(CODE_BEL);
						default: push_char(b);
					endcase
				end
			end
			MODE_CONT: begin
				if (b == CH_BSLASH) begin
					mode = MODE_ESC;
				end else begin
					mode = MODE_NORMAL;
					push_char(b);
				end
			end
			MODE_DEC1: begin
				if (is_dig) begin
					dec_acc = 7'((v * 10 + d) & 127);
					mode = MODE_DEC2;
				end else begin
					dec_acc = 7'd0;
					push_char(8'(v));
					text_byte(b);
				end
			end
			MODE_DEC2: begin
				dec_acc = 7'd0;
				if (is_dig && (v * 10 + d) < 128) begin
					mode = MODE_NORMAL;
					push_char(8'(v * 10 + d));
				end else begin
					push_char(8'(v));
					text_byte(b);
				end
			end
			default: text_byte(b);
		endcase
		for (int i = 0; i < byte_results.size(); i++) begin
			if (i == byte_results.size() - 1)
				byte_results[i].last = 1'b1;
			decoded_q.push_back(byte_results[i]);
		end
	endfunction

	function automatic void add(logic [7:0] b);
		raw_t r;
		r.b     = b;
		r.drain = 1'b0;
		pending.push_back(r);
	endfunction

	function automatic logic [7:0] digit(int n);
		return CH_ZERO + 8'(n);
	endfunction

	function automatic logic [7:0] printable();
		logic [7:0] c;
		c = 8'($urandom_range(32, 126));
		if (c == CH_BSLASH || c == CH_QUOTE)
			c = 8'h78;
		return c;
	endfunction

	// Input side: a new transaction is offered only once the previous one has been taken.
	always @(negedge clk) begin
		logic       nv;
		logic [7:0] nb;
		logic       nr;
		bit         calm;
		raw_t       head;
		nv = in_valid;
		nb = in_byte;
		nr = out_ready;
		calm = (pending.size() < QUIET_TAIL) || ((cycles / 400) % 3 == 0);
		if (arst_n) begin
			if (in_taken)
				nv = 1'b0;
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending.size() > 0 &&
						!(pending[0].drain && decoded_q.size() != 0)) begin
					head = pending.pop_front();
					nb = head.b;
					nv = 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 4);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				nr = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				recv_gap = $urandom_range(0, 3);
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
		end
		in_valid  <= nv;
		in_byte   <= nb;
		out_ready <= nr;
	end

	// Output side: every result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n) begin
			cycles++;
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: out_char %0d char_valid %0b string_end %0b",
						out_char, char_valid, string_end);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					if (out_char !== want.ch) begin
						$error("out_char: expected %0d, got %0d", want.ch, out_char);
						errors++;
					end
					if (char_valid !== want.char_ok) begin
						$error("char_valid: expected %0b, got %0b", want.char_ok, char_valid);
						errors++;
					end
					if (string_end !== want.str_end) begin
						$error("string_end: expected %0b, got %0b", want.str_end, string_end);
						errors++;
					end
					if (run_last !== want.last) begin
						$error("run_last: expected %0b, got %0b", want.last, run_last);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				decode_byte(in_byte);
			in_taken = in_valid && in_ready;
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("string_escape_decoder_tb failed");
		$finish;
	end

	initial begin
		int directed_n;
		int kind;
		int ndig;
		int pick;
		logic [7:0] named [5];
		named = '{CH_R, CH_N, CH_T, CH_V, CH_A};

		// Extremes of the byte, every named escape, an ordinary escape and the quote.
		add(8'h00);
		add(8'hFF);
		add(CH_QUOTE);
		foreach (named[i]) begin
			add(CH_BSLASH);
			add(named[i]);
		end
		add(CH_BSLASH);
		add(8'h71);
		// Line continuation followed by a quote taken literally, then by a new escape.
		add(CH_BSLASH);
		add(CH_NL);
		add(CH_QUOTE);
		add(CH_BSLASH);
		add(CH_NL);
		add(CH_BSLASH);
		add(CH_T);
		// Decimal escapes: three digits that fit, a third digit that overflows, and
		// an escape cut short by the closing quote.
		add(CH_BSLASH);
		add(digit(1));
		add(digit(2));
		add(digit(7));
		add(CH_BSLASH);
		add(digit(1));
		add(digit(2));
		add(digit(8));
		add(CH_BSLASH);
		add(digit(9));
		add(digit(9));
		add(CH_QUOTE);
		directed_n = pending.size();

		while (pending.size() < ITEM_TARGET) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: add(8'($urandom_range(0, 255)));
				1, 2: add(printable());
				3: begin
					add(CH_BSLASH);
					add(8'($urandom_range(0, 255)));
				end
				4: begin
					add(CH_BSLASH);
					add(named[$urandom_range(0, 4)]);
				end
				5: begin
					add(CH_BSLASH);
					add(CH_NL);
					pick = $urandom_range(0, 3);
					if (pick == 0)
						add(CH_QUOTE);
					else if (pick == 1)
						add(CH_BSLASH);
					else
						add(8'($urandom_range(0, 255)));
				end
				6, 7, 9: begin
					add(CH_BSLASH);
					if (kind == 9) begin
						// Values around the limit of a three-digit escape.
						add(digit(1));
						add(digit(2));
						add(digit($urandom_range(0, 9)));
					end else begin
						ndig = $urandom_range(1, 3);
						for (int i = 0; i < ndig; i++)
							add(digit($urandom_range(0, 9)));
					end
					pick = $urandom_range(0, 4);
					if (pick == 0)
						add(CH_QUOTE);
					else if (pick == 1)
						add(CH_BSLASH);
					else if (pick == 2)
						add(digit($urandom_range(0, 9)));
					else if (pick == 3)
						add(printable());
					else
						add(8'($urandom_range(0, 255)));
				end
				default: add(CH_QUOTE);
			endcase
		end
		// The sender holds back at these points until every outstanding result is in.
		pending[directed_n].drain = 1'b1;
		pending[ITEM_TARGET / 2].drain = 1'b1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending.size() == 0 && !in_valid);
		wait (decoded_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("string_escape_decoder_tb passed");
		else
			$display("string_escape_decoder_tb failed");
		$finish;
	end

endmodule

>>> filelist.f
design/sed_pkg.sv
design/sed_front.sv
design/sed_queue.sv
design/sed_back.sv
design/string_escape_decoder.sv
tb/string_escape_decoder_tb.sv
